### sv/i2c_mts_pkg.sv
// Shared types, constants and helpers of the I2C transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2c_mts_pkg;

  // Request FIFO slots; the ring holds one request fewer than this.
  localparam int QUEUE_DEPTH = 8;
  // Largest byte count of one write or read phase.
  localparam int MAX_BYTES   = 16;

  localparam int QPtrW   = $clog2(QUEUE_DEPTH);
  localparam int StoreAw = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int LenW    = 5;
  localparam int AddrW   = 7;

  // Bit positions in the engine flag field.
  localparam int FLAG_START_BUSY   = 0;
  localparam int FLAG_TX_BUSY      = 1;
  localparam int FLAG_NACK         = 2;
  localparam int FLAG_RESTART_BUSY = 3;
  localparam int FLAG_ACK_BUSY     = 4;
  localparam int FLAG_RX_BUSY      = 5;
  localparam int FLAG_STOP_BUSY    = 6;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_TICK    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_WRITE   = 3'd2,
    PH_RESTART = 3'd3,
    PH_READ    = 3'd4,
    PH_RECV    = 3'd5,
    PH_STOP    = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_TX      = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_RCEN    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_STOP    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_FINISHED = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  typedef struct packed {
    logic [LenW-1:0]  rlen;
    logic [LenW-1:0]  wlen;
    logic [AddrW-1:0] addr;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       ack;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic [3:0] rd_pos;
    status_e    status;
    logic       dropped;
  } result_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
    logic [LenW-1:0] r;
    r = v;
    if (int'(v) > MAX_BYTES) begin
      r = LenW'(MAX_BYTES);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/i2c_mts_req_fifo.sv
// Ring FIFO of pending I2C requests with full and empty status.
`timescale 1ns / 1ps
`default_nettype none

module i2c_mts_req_fifo (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  input  wire                         pop_i,
  input  wire i2c_mts_pkg::req_t      push_data_i,
  output i2c_mts_pkg::req_t           head_data_o,
  output i2c_mts_pkg::fifo_status_t   status_o
);

  localparam int PtrW = i2c_mts_pkg::QPtrW;

  i2c_mts_pkg::req_t slots_q [i2c_mts_pkg::QUEUE_DEPTH];

  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [PtrW-1:0] tail_next;
  logic [PtrW-1:0] head_next;

  always_comb begin
    tail_next = (int'(tail_q) == i2c_mts_pkg::QUEUE_DEPTH - 1) ? '0 : tail_q + 1'b1;
    head_next = (int'(head_q) == i2c_mts_pkg::QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
  end

  always_comb begin
    status_o.empty = (head_q == tail_q);
    status_o.full  = (tail_next == head_q);
    head_data_o    = slots_q[head_q];
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (push_i && !status_o.full) begin
      tail_d = tail_next;
    end
    if (pop_i && !status_o.empty) begin
      head_d = head_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !status_o.full) begin
      slots_q[tail_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### sv/i2c_master_transaction_sequencer_core.sv
// Top level of the I2C master write/read transaction sequencer.
//
// One input channel (in_valid_i/in_ready_o) carries three kinds of beat:
// an enqueue of a request (address, write count, read count), a load of one
// write data byte into the store, and a tick with the bus engine's flags and
// the received byte. Every accepted beat yields exactly one result beat on
// the output channel (out_valid_o/out_ready_i): the bus command to issue,
// the byte to transmit, the ack level, a received byte with its index, the
// request status and a dropped flag for an enqueue into a full FIFO.
// Each result is registered, in the result register or, while that is held,
// in the skid stage. Throughput is one beat per cycle while in_ready_o is
// high; the sequencer state, the FIFO pointers and the write store all
// update in the cycle of acceptance. The result register is backed by a
// one-entry skid stage, so a stalled receiver costs no input cycle until
// both are full; then in_ready_o drops until the receiver takes a result.
// Reset empties the FIFO, returns the sequencer to idle with status
// pending and clears both output stages. The request slots and the write
// store are not cleared; the host loads write data before each request.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [1:0]  kind_i,
  input  wire [6:0]  target_address_i,
  input  wire [4:0]  write_length_i,
  input  wire [4:0]  read_length_i,
  input  wire [3:0]  data_index_i,
  input  wire [7:0]  data_byte_i,
  input  wire [6:0]  engine_flags_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [2:0] bus_command_o,
  output logic [7:0] transmit_byte_o,
  output logic       ack_level_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic [3:0] read_position_o,
  output logic [1:0] request_status_o,
  output logic       request_dropped_o
);

  localparam int StoreAw = i2c_mts_pkg::StoreAw;
  localparam int LenW    = i2c_mts_pkg::LenW;

  logic accept;
  i2c_mts_pkg::kind_e kind;

  // Request FIFO
  logic                      push, pop;
  i2c_mts_pkg::req_t         push_req, head_req;
  i2c_mts_pkg::fifo_status_t fifo_st;

  // Sequencer state
  i2c_mts_pkg::phase_e  phase_q, phase_d;
  i2c_mts_pkg::status_e status_q, status_d;
  i2c_mts_pkg::req_t    cur_q, cur_d;
  logic [LenW-1:0]      cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 run_eff;
  logic                 tick;

  // Write data store
  logic [7:0] store_q [i2c_mts_pkg::MAX_BYTES];
  logic       store_we;
  logic [7:0] store_rd;

  // Output stages
  i2c_mts_pkg::result_t res_d, out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = i2c_mts_pkg::kind_e'(kind_i);
  assign tick       = accept && (kind == i2c_mts_pkg::KIND_TICK);
  assign run_eff    = run_q || !fifo_st.empty;

  always_comb begin
    push_req.addr = target_address_i;
    push_req.wlen = i2c_mts_pkg::clamp_len(write_length_i);
    push_req.rlen = i2c_mts_pkg::clamp_len(read_length_i);
  end

  i2c_mts_req_fifo u_req_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .push_data_i (push_req),
    .head_data_o (head_req),
    .status_o    (fifo_st)
  );

  assign store_rd = (int'(cnt_q) < i2c_mts_pkg::MAX_BYTES) ?
                    store_q[StoreAw'(cnt_q)] : 8'h00;

  // Next state of the sequencer, FIFO and store.
  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    push     = 1'b0;
    pop      = 1'b0;
    store_we = 1'b0;
    if (accept) begin
      unique case (kind)
        i2c_mts_pkg::KIND_ENQUEUE: push = !fifo_st.full;
        i2c_mts_pkg::KIND_LOAD:
          store_we = (int'(data_index_i) < i2c_mts_pkg::MAX_BYTES);
        i2c_mts_pkg::KIND_TICK: begin
          run_d = run_eff;
          if (run_eff) begin
            unique case (phase_q)
              i2c_mts_pkg::PH_IDLE: begin
                if (!fifo_st.empty) begin
                  cur_d = head_req;
                  pop   = 1'b1;
                end
                status_d = i2c_mts_pkg::ST_PENDING;
                phase_d  = i2c_mts_pkg::PH_START;
              end
              i2c_mts_pkg::PH_START: begin
                if (!engine_flags_i[i2c_mts_pkg::FLAG_START_BUSY]) begin
                  if (cur_q.wlen != '0) begin
                    phase_d = i2c_mts_pkg::PH_WRITE;
                  end else if (cur_q.rlen != '0) begin
                    phase_d = i2c_mts_pkg::PH_READ;
                  end else begin
                    status_d = i2c_mts_pkg::ST_FINISHED;
                    cnt_d    = '0;
                    phase_d  = i2c_mts_pkg::PH_STOP;
                  end
                end
              end
              i2c_mts_pkg::PH_WRITE: begin
                if (!engine_flags_i[i2c_mts_pkg::FLAG_TX_BUSY]) begin
                  if (engine_flags_i[i2c_mts_pkg::FLAG_NACK]) begin
                    status_d = i2c_mts_pkg::ST_ERROR;
                    cnt_d    = '0;
                    phase_d  = i2c_mts_pkg::PH_STOP;
                  end else if (cnt_q < cur_q.wlen) begin
                    cnt_d = cnt_q + 1'b1;
                  end else begin
                    cnt_d   = '0;
                    phase_d = i2c_mts_pkg::PH_RESTART;
                  end
                end
              end
              i2c_mts_pkg::PH_RESTART: begin
                if (!engine_flags_i[i2c_mts_pkg::FLAG_RESTART_BUSY]) begin
                  phase_d = i2c_mts_pkg::PH_READ;
                end
              end
              i2c_mts_pkg::PH_READ: begin
                if (!engine_flags_i[i2c_mts_pkg::FLAG_TX_BUSY]) begin
                  if (engine_flags_i[i2c_mts_pkg::FLAG_NACK]) begin
                    status_d = i2c_mts_pkg::ST_ERROR;
                    cnt_d    = '0;
                    phase_d  = i2c_mts_pkg::PH_STOP;
                  end else if (!engine_flags_i[i2c_mts_pkg::FLAG_ACK_BUSY]) begin
                    if (cnt_q < cur_q.rlen) begin
                      cnt_d   = cnt_q + 1'b1;
                      phase_d = i2c_mts_pkg::PH_RECV;
                    end else begin
                      status_d = i2c_mts_pkg::ST_FINISHED;
                      cnt_d    = '0;
                      phase_d  = i2c_mts_pkg::PH_STOP;
                    end
                  end
                end
              end
              i2c_mts_pkg::PH_RECV: begin
                if (!engine_flags_i[i2c_mts_pkg::FLAG_RX_BUSY]) begin
                  phase_d = i2c_mts_pkg::PH_READ;
                end
              end
              i2c_mts_pkg::PH_STOP: begin
                if (!engine_flags_i[i2c_mts_pkg::FLAG_STOP_BUSY]) begin
                  run_d   = 1'b0;
                  phase_d = i2c_mts_pkg::PH_IDLE;
                end
              end
              default: phase_d = i2c_mts_pkg::PH_IDLE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the beat being accepted.
  always_comb begin
    res_d          = '0;
    res_d.cmd      = i2c_mts_pkg::CMD_NONE;
    res_d.status   = status_d;
    res_d.dropped  = accept && (kind == i2c_mts_pkg::KIND_ENQUEUE) && fifo_st.full;
    if (tick && run_eff) begin
      unique case (phase_q)
        i2c_mts_pkg::PH_IDLE: res_d.cmd = i2c_mts_pkg::CMD_START;
        i2c_mts_pkg::PH_START: begin
          if (!engine_flags_i[i2c_mts_pkg::FLAG_START_BUSY]) begin
            if (cur_q.wlen != '0) begin
              res_d.cmd     = i2c_mts_pkg::CMD_TX;
              res_d.tx_byte = {cur_q.addr, 1'b0};
            end else if (cur_q.rlen != '0) begin
              res_d.cmd     = i2c_mts_pkg::CMD_TX;
              res_d.tx_byte = {cur_q.addr, 1'b1};
            end else begin
              res_d.cmd = i2c_mts_pkg::CMD_STOP;
            end
          end
        end
        i2c_mts_pkg::PH_WRITE: begin
          if (!engine_flags_i[i2c_mts_pkg::FLAG_TX_BUSY]) begin
            if (engine_flags_i[i2c_mts_pkg::FLAG_NACK]) begin
              res_d.cmd = i2c_mts_pkg::CMD_STOP;
            end else if (cnt_q < cur_q.wlen) begin
              res_d.cmd     = i2c_mts_pkg::CMD_TX;
              res_d.tx_byte = store_rd;
            end else begin
              res_d.cmd = i2c_mts_pkg::CMD_RESTART;
            end
          end
        end
        i2c_mts_pkg::PH_RESTART: begin
          if (!engine_flags_i[i2c_mts_pkg::FLAG_RESTART_BUSY]) begin
            res_d.cmd     = i2c_mts_pkg::CMD_TX;
            res_d.tx_byte = {cur_q.addr, 1'b1};
          end
        end
        i2c_mts_pkg::PH_READ: begin
          if (!engine_flags_i[i2c_mts_pkg::FLAG_TX_BUSY]) begin
            if (engine_flags_i[i2c_mts_pkg::FLAG_NACK]) begin
              res_d.cmd = i2c_mts_pkg::CMD_STOP;
            end else if (!engine_flags_i[i2c_mts_pkg::FLAG_ACK_BUSY]) begin
              res_d.cmd = (cnt_q < cur_q.rlen) ? i2c_mts_pkg::CMD_RCEN :
                                                 i2c_mts_pkg::CMD_STOP;
            end
          end
        end
        i2c_mts_pkg::PH_RECV: begin
          if (!engine_flags_i[i2c_mts_pkg::FLAG_RX_BUSY]) begin
            // The counter already points past the byte being delivered.
            res_d.cmd      = i2c_mts_pkg::CMD_ACK;
            res_d.rd_valid = 1'b1;
            res_d.rd_byte  = data_byte_i;
            res_d.rd_pos   = 4'(cnt_q - 1'b1);
            res_d.ack      = (cnt_q >= cur_q.rlen);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2c_mts_pkg::PH_IDLE;
      status_q <= i2c_mts_pkg::ST_PENDING;
      cur_q    <= '0;
      cnt_q    <= '0;
      run_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      cur_q    <= cur_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[StoreAw'(data_index_i)] <= data_byte_i;
    end
  end

  // Result register with a skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign bus_command_o     = out_q.cmd;
  assign transmit_byte_o   = out_q.tx_byte;
  assign ack_level_o       = out_q.ack;
  assign read_valid_o      = out_q.rd_valid;
  assign read_byte_o       = out_q.rd_byte;
  assign read_position_o   = out_q.rd_pos;
  assign request_status_o  = out_q.status;
  assign request_dropped_o = out_q.dropped;

  // The skid stage only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while result register empty");

  // A received byte is only ever reported together with an acknowledge.
  a_read_with_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rd_valid) |-> (out_q.cmd == i2c_mts_pkg::CMD_ACK))
    else $error("received byte delivered without acknowledge command");

  // The sequencer is running exactly when it has left idle.
  a_run_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != (phase_q == i2c_mts_pkg::PH_IDLE))
    else $error("run flag disagrees with phase");

  // Every entry into stop clears the byte counter, so idle starts from zero.
  a_idle_counter_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == i2c_mts_pkg::PH_IDLE) |-> (cnt_q == '0))
    else $error("byte counter not cleared in idle");

endmodule

`default_nettype wire

### tb/i2c_master_transaction_sequencer_core_tb.sv
// Self-checking testbench of the I2C master write/read transaction sequencer core.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_core_tb;
  import i2c_mts_pkg::*;

  // The input kind field has a fourth code that the block ignores.
  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] addr;
    logic [4:0] wlen;
    logic [4:0] rlen;
    logic [3:0] idx;
    logic [7:0] dbyte;
    logic [6:0] flags;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i = '0;
  logic [6:0] target_address_i = '0;
  logic [4:0] write_length_i = '0;
  logic [4:0] read_length_i = '0;
  logic [3:0] data_index_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [6:0] engine_flags_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b1;
  logic [2:0] bus_command_o;
  logic [7:0] transmit_byte_o;
  logic       ack_level_o;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic [3:0] read_position_o;
  logic [1:0] request_status_o;
  logic       request_dropped_o;

  i2c_master_transaction_sequencer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .target_address_i (target_address_i),
    .write_length_i   (write_length_i),
    .read_length_i    (read_length_i),
    .data_index_i     (data_index_i),
    .data_byte_i      (data_byte_i),
    .engine_flags_i   (engine_flags_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bus_command_o    (bus_command_o),
    .transmit_byte_o  (transmit_byte_o),
    .ack_level_o      (ack_level_o),
    .read_valid_o     (read_valid_o),
    .read_byte_o      (read_byte_o),
    .read_position_o  (read_position_o),
    .request_status_o (request_status_o),
    .request_dropped_o(request_dropped_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sequencer state as the testbench expects it.
  req_t        req_slots [QUEUE_DEPTH];
  int unsigned q_head = 0;
  int unsigned q_tail = 0;
  logic [7:0]  wr_store [MAX_BYTES];
  req_t        cur_req = '0;
  phase_e      seq_phase = PH_IDLE;
  int unsigned xfer_count = 0;
  bit          running = 1'b0;
  status_e     cur_status = ST_PENDING;

  logic [MAX_BYTES-1:0] store_loaded = '0;
  result_t     expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned beats_checked = 0;
  int unsigned reads_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned requests_done = 0;
  int unsigned requests_failed = 0;

  function automatic logic [4:0] byte_count(input logic [4:0] v);
    return (v > MAX_BYTES) ? 5'(MAX_BYTES) : v;
  endfunction

  function automatic cmd_e begin_stop(input status_e st);
    cur_status = st;
    xfer_count = 0;
    seq_phase  = PH_STOP;
    return CMD_STOP;
  endfunction

  // Advances the expected state by one accepted beat and returns its result.
  function automatic result_t sequence_step(input beat_t b);
    result_t r;
    int unsigned nxt;
    r = '0;
    case (b.kind)
      KIND_ENQUEUE: begin
        nxt = (q_tail + 1) % QUEUE_DEPTH;
        if (nxt == q_head) begin
          r.dropped = 1'b1;
        end else begin
          req_slots[q_tail] = '{rlen: byte_count(b.rlen), wlen: byte_count(b.wlen),
                                addr: b.addr};
          q_tail = nxt;
        end
      end
      KIND_LOAD: begin
        if (b.idx < MAX_BYTES) wr_store[b.idx] = b.dbyte;
      end
      KIND_TICK: begin
        if (q_head != q_tail) running = 1'b1;
        if (running) begin
          case (seq_phase)
            PH_IDLE: begin
              if (q_head != q_tail) begin
                cur_req = req_slots[q_head];
                q_head  = (q_head + 1) % QUEUE_DEPTH;
              end
              cur_status = ST_PENDING;
              r.cmd      = CMD_START;
              seq_phase  = PH_START;
            end
            PH_START: begin
              if (!b.flags[FLAG_START_BUSY]) begin
                if (cur_req.wlen > 0) begin
                  r.cmd     = CMD_TX;
                  r.tx_byte = {cur_req.addr, 1'b0};
                  seq_phase = PH_WRITE;
                end else if (cur_req.rlen > 0) begin
                  r.cmd     = CMD_TX;
                  r.tx_byte = {cur_req.addr, 1'b1};
                  seq_phase = PH_READ;
                end else begin
                  r.cmd = begin_stop(ST_FINISHED);
                end
              end
            end
            PH_WRITE: begin
              if (!b.flags[FLAG_TX_BUSY]) begin
                if (b.flags[FLAG_NACK]) begin
                  r.cmd = begin_stop(ST_ERROR);
                end else if (xfer_count < cur_req.wlen) begin
                  r.cmd     = CMD_TX;
                  r.tx_byte = (xfer_count < MAX_BYTES) ? wr_store[xfer_count] : 8'd0;
                  xfer_count++;
                end else begin
                  xfer_count = 0;
                  r.cmd      = CMD_RESTART;
                  seq_phase  = PH_RESTART;
                end
              end
            end
            PH_RESTART: begin
              if (!b.flags[FLAG_RESTART_BUSY]) begin
                r.cmd     = CMD_TX;
                r.tx_byte = {cur_req.addr, 1'b1};
                seq_phase = PH_READ;
              end
            end
            PH_READ: begin
              if (!b.flags[FLAG_TX_BUSY]) begin
                if (b.flags[FLAG_NACK]) begin
                  r.cmd = begin_stop(ST_ERROR);
                end else if (!b.flags[FLAG_ACK_BUSY]) begin
                  if (xfer_count < cur_req.rlen) begin
                    xfer_count++;
                    r.cmd     = CMD_RCEN;
                    seq_phase = PH_RECV;
                  end else begin
                    r.cmd = begin_stop(ST_FINISHED);
                  end
                end
              end
            end
            PH_RECV: begin
              if (!b.flags[FLAG_RX_BUSY]) begin
                r.rd_valid = 1'b1;
                r.rd_byte  = b.dbyte;
                r.rd_pos   = 4'(xfer_count - 1);
                r.ack      = (xfer_count >= cur_req.rlen);
                r.cmd      = CMD_ACK;
                seq_phase  = PH_READ;
              end
            end
            PH_STOP: begin
              if (!b.flags[FLAG_STOP_BUSY]) begin
                running   = 1'b0;
                seq_phase = PH_IDLE;
              end
            end
            default: seq_phase = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
    r.status = cur_status;
    return r;
  endfunction

  function automatic beat_t random_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(beat_t)-1:0];
  endfunction

  function automatic logic [4:0] pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 5'($urandom_range(3));
    if (p < 90) return 5'($urandom_range(MAX_BYTES));
    return 5'($urandom_range(31, MAX_BYTES + 1));
  endfunction

  function automatic logic [6:0] random_flags();
    logic [6:0] f;
    for (int i = 0; i < 7; i++) f[i] = ($urandom_range(99) < 20);
    f[FLAG_NACK] = ($urandom_range(99) < 2);
    return f;
  endfunction

  // Presents one beat and waits for it to be taken. Called and left just
  // after a falling edge; valid only drops when a gap is inserted.
  task automatic send_beat(input beat_t b);
    bit gap;
    gap = ($urandom_range(99) < send_idle_pct);
    if (gap) begin
      in_valid_i <= 1'b0;
      while (gap) begin
        @(negedge clk_i);
        gap = ($urandom_range(99) < send_idle_pct);
      end
    end
    kind_i           <= b.kind;
    target_address_i <= b.addr;
    write_length_i   <= b.wlen;
    read_length_i    <= b.rlen;
    data_index_i     <= b.idx;
    data_byte_i      <= b.dbyte;
    engine_flags_i   <= b.flags;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(sequence_step(b));
    if (b.kind == KIND_LOAD) store_loaded[b.idx] = 1'b1;
    @(negedge clk_i);
  endtask

  // Makes sure every write byte the request will send has been loaded first.
  task automatic queue_request(input beat_t b);
    beat_t ld;
    for (int i = 0; i < byte_count(b.wlen); i++) begin
      if (!store_loaded[i]) begin
        ld = random_beat();
        ld.kind = KIND_LOAD;
        ld.idx  = 4'(i);
        send_beat(ld);
      end
    end
    send_beat(b);
  endtask

  task automatic tick(input logic [6:0] flags, input logic [7:0] rx_byte);
    send_beat('{kind: KIND_TICK, addr: '0, wlen: '0, rlen: '0, idx: '0,
                dbyte: rx_byte, flags: flags});
  endtask

  task automatic enqueue(input logic [6:0] addr, input logic [4:0] wl, input logic [4:0] rl);
    queue_request('{kind: KIND_ENQUEUE, addr: addr, wlen: wl, rlen: rl, idx: '0,
                    dbyte: '0, flags: '0});
  endtask

  // Always lets at least one falling edge pass with valid low.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic test_load_and_ignored();
    send_beat('{kind: KIND_LOAD, addr: '0, wlen: '0, rlen: '0, idx: 4'd0,
                dbyte: 8'hFF, flags: '0});
    send_beat('1);
  endtask

  // No bytes either way: start, a busy tick, then stop as finished.
  task automatic test_empty_request();
    enqueue(7'd0, 5'd0, 5'd0);
    tick(7'h00, 8'h00);
    tick(7'h7F, 8'h00);
    tick(7'h00, 8'h00);
    tick(7'h00, 8'h00);
  endtask

  task automatic test_write_read();
    enqueue(7'h7F, 5'd1, 5'd1);
    repeat (6) tick(7'h00, 8'h00);
    tick(7'h00, 8'hFF);
    tick(7'h00, 8'h00);
    tick(7'h00, 8'h00);
  endtask

  // The slave refuses the read address: the request stops with an error.
  task automatic test_nack_error();
    enqueue(7'h2A, 5'd0, 5'd2);
    tick(7'h00, 8'h00);
    tick(7'h00, 8'h00);
    tick(7'(1 << FLAG_NACK), 8'h00);
    tick(7'h00, 8'h00);
  endtask

  // With the sender held back until all results are in, a burst of
  // enqueues with no tick in between must overflow the ring.
  task automatic test_queue_full();
    beat_t b;
    drain_results();
    repeat (QUEUE_DEPTH) begin
      b = random_beat();
      b.kind = KIND_ENQUEUE;
      b.wlen = pick_length();
      b.rlen = pick_length();
      queue_request(b);
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_beats, input int unsigned idle_pct,
                                     input int unsigned stall);
    beat_t b;
    int unsigned done_cnt;
    int unsigned pick;
    int unsigned queued;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    done_cnt      = 0;
    while (done_cnt < n_beats) begin
      b      = random_beat();
      pick   = $urandom_range(99);
      queued = (q_tail + QUEUE_DEPTH - q_head) % QUEUE_DEPTH;
      if (pick < 3) begin
        b.kind = KIND_IGNORED;
        send_beat(b);
      end else begin
        if (pick < 8) begin
          b.kind = KIND_LOAD;
          send_beat(b);
        end else if (pick < ((queued < 2) ? 28 : 11)) begin
          b.kind = KIND_ENQUEUE;
          b.wlen = pick_length();
          b.rlen = pick_length();
          queue_request(b);
        end else begin
          b.kind  = KIND_TICK;
          b.flags = random_flags();
          send_beat(b);
        end
        done_cnt++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual command %0d",
                 $time, bus_command_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("bus_command", want.cmd, bus_command_o);
        check_field("transmit_byte", want.tx_byte, transmit_byte_o);
        check_field("ack_level", want.ack, ack_level_o);
        check_field("read_valid", want.rd_valid, read_valid_o);
        check_field("read_byte", want.rd_byte, read_byte_o);
        check_field("read_position", want.rd_pos, read_position_o);
        check_field("request_status", want.status, request_status_o);
        check_field("request_dropped", want.dropped, request_dropped_o);
        beats_checked++;
        if (want.rd_valid) reads_seen++;
        if (want.dropped) drops_seen++;
        if (want.cmd == CMD_STOP && want.status == ST_FINISHED) requests_done++;
        if (want.cmd == CMD_STOP && want.status == ST_ERROR) requests_failed++;
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results still expected", expected_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_load_and_ignored();
    test_empty_request();
    test_write_read();
    test_nack_error();
    test_random_traffic(480, 0, 0);
    test_queue_full();
    test_random_traffic(480, 80, 0);
    test_random_traffic(480, 0, 80);
    test_random_traffic(480, 8, 8);

    drain_results();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d result beats: %0d requests finished, %0d ended on a NACK,",
             beats_checked, requests_done, requests_failed);
    $display("%0d bytes received, %0d enqueues dropped on a full FIFO.",
             reads_seen, drops_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
